// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that sleeps while reset is held.
`define SSP_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Concurrent assertion that is checked at every edge, reset included.
`define SSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ssp_pkg.sv =====
// Package with widths, types and helpers of the stripe scroll parameter core.
`default_nettype none

package ssp_pkg;

  localparam int PERIOD_W = 9;
  localparam int FRAME_W  = 16;
  localparam int COLOR_W  = 12;
  localparam int OFFSET_W = 17;
  localparam int PROD_W   = PERIOD_W + FRAME_W;  // signed product of period and frame
  localparam int SHIFT_W  = PROD_W - 3;          // product after the shift by three
  localparam int DVD_W    = SHIFT_W + 1;         // sum with the center offset
  localparam int ROW_W    = 13;
  localparam int BANK_W   = 3;
  localparam int SCROLL_W = 8;

  localparam logic [OFFSET_W-1:0] CENTER_OFFSET_RST = 17'h1FB00;  // -1280
  localparam int MIN_PERIOD_DEF = 168;
  localparam int ROW_BYTES_DEF  = 48;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [COLOR_W-1:0]  color_first;
    logic [COLOR_W-1:0]  color_second;
  } ssp_side_t;

  typedef struct packed {
    logic                neg;   // dividend was negative
    logic [PERIOD_W-1:0] rem;   // partial remainder
    logic [DVD_W-1:0]    dvd;   // dividend bits not yet shifted in
    logic                qlsb;  // last quotient bit produced
    ssp_side_t           side;
  } ssp_cell_t;

  typedef struct packed {
    logic [BANK_W-1:0]   pattern_bank;
    logic [ROW_W-1:0]    row_byte_address;
    logic [SCROLL_W-1:0] scroll_code;
    logic [COLOR_W-1:0]  color_out_a;
    logic [COLOR_W-1:0]  color_out_b;
  } ssp_res_t;

  // (15 - n) * 0x11 for a nibble n: both nibbles are the complement of n.
  function automatic logic [SCROLL_W-1:0] scroll_of(input logic [3:0] nib);
    return {~nib, ~nib};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ssp_front.sv =====
// Front stages: period times frame, then shift, center offset and magnitude.
`default_nettype none

module ssp_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              en,
  input  wire                              valid_i,
  input  wire [ssp_pkg::PERIOD_W-1:0]      stripe_period,
  input  wire [ssp_pkg::FRAME_W-1:0]       frame_number,
  input  wire [ssp_pkg::COLOR_W-1:0]       color_first,
  input  wire [ssp_pkg::COLOR_W-1:0]       color_second,
  input  wire [ssp_pkg::OFFSET_W-1:0]      center_offset,
  output logic                             valid_o,
  output ssp_pkg::ssp_cell_t               cell_o
);

  logic                             mul_valid_r;
  logic signed [ssp_pkg::PROD_W-1:0] prod_r;
  ssp_pkg::ssp_side_t               mul_side_r;
  logic signed [ssp_pkg::PROD_W-1:0] prod_full;

  logic                             div_valid_r;
  ssp_pkg::ssp_cell_t               div_cell_r;
  logic signed [ssp_pkg::DVD_W-1:0] sum;
  logic [ssp_pkg::DVD_W-1:0]        mag;
  ssp_pkg::ssp_cell_t               div_cell_nxt;

  assign prod_full = $signed({1'b0, stripe_period}) * $signed(frame_number);

  // Arithmetic shift by three, then add the sign-extended offset.
  assign sum = $signed({prod_r[ssp_pkg::PROD_W-1], prod_r[ssp_pkg::PROD_W-1:3]})
             + $signed({{(ssp_pkg::DVD_W-ssp_pkg::OFFSET_W){center_offset[ssp_pkg::OFFSET_W-1]}},
                        center_offset});
  assign mag = sum[ssp_pkg::DVD_W-1] ? (~sum + 1'b1) : sum;

  always_comb begin
    div_cell_nxt.neg  = sum[ssp_pkg::DVD_W-1];
    div_cell_nxt.rem  = '0;
    div_cell_nxt.dvd  = mag;
    div_cell_nxt.qlsb = 1'b0;
    div_cell_nxt.side = mul_side_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      div_valid_r <= 1'b0;
    end else if (en) begin
      mul_valid_r <= valid_i;
      div_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r                  <= prod_full;
      mul_side_r.period       <= stripe_period;
      mul_side_r.color_first  <= color_first;
      mul_side_r.color_second <= color_second;
      div_cell_r              <= div_cell_nxt;
    end
  end

  assign valid_o = div_valid_r;
  assign cell_o  = div_cell_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ssp_div_cell.sv =====
// One restoring division cell: shift in a dividend bit, trial subtract the period.
`default_nettype none

module ssp_div_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  wire                 valid_i,
  input  ssp_pkg::ssp_cell_t  cell_i,
  output logic                valid_o,
  output ssp_pkg::ssp_cell_t  cell_o
);

  logic                       valid_r;
  ssp_pkg::ssp_cell_t         cell_r;
  ssp_pkg::ssp_cell_t         cell_nxt;
  logic [ssp_pkg::PERIOD_W:0] trial;
  logic [ssp_pkg::PERIOD_W:0] diff;
  logic                       take;

  assign trial = {cell_i.rem, cell_i.dvd[ssp_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, cell_i.side.period};
  assign take  = (trial >= {1'b0, cell_i.side.period});

  always_comb begin
    cell_nxt      = cell_i;
    cell_nxt.rem  = take ? diff[ssp_pkg::PERIOD_W-1:0] : trial[ssp_pkg::PERIOD_W-1:0];
    cell_nxt.dvd  = {cell_i.dvd[ssp_pkg::DVD_W-2:0], 1'b0};
    cell_nxt.qlsb = take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign valid_o = valid_r;
  assign cell_o  = cell_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ssp_out.sv =====
// Result stage: remainder fix-up, field forming, output register and skid entry.
`default_nettype none

module ssp_out #(
  parameter int MIN_PERIOD = ssp_pkg::MIN_PERIOD_DEF,
  parameter int ROW_BYTES  = ssp_pkg::ROW_BYTES_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 valid_i,
  input  ssp_pkg::ssp_cell_t  cell_i,
  output logic                en,
  output logic                out_valid,
  input  wire                 out_ready,
  output ssp_pkg::ssp_res_t   res_o
);

  localparam logic [ssp_pkg::ROW_W-1:0] MIN_L = ssp_pkg::ROW_W'(MIN_PERIOD);
  localparam logic [ssp_pkg::ROW_W-1:0] ROW_L = ssp_pkg::ROW_W'(ROW_BYTES);

  logic                            zero_per;
  logic                            fix;
  logic [ssp_pkg::PERIOD_W-1:0]    r;
  logic                            odd;
  logic [ssp_pkg::ROW_W-1:0]       row_diff;
  logic [ssp_pkg::ROW_W-1:0]       row_full;
  logic [ssp_pkg::ROW_W-1:0]       row_off;
  ssp_pkg::ssp_res_t               res;
  logic                            arrive;

  logic                            out_valid_r;
  logic                            out_valid_nxt;
  ssp_pkg::ssp_res_t               out_data_r;
  ssp_pkg::ssp_res_t               out_data_nxt;
  logic                            skid_valid_r;
  logic                            skid_valid_nxt;
  ssp_pkg::ssp_res_t               skid_data_r;

  // Truncating divide of a negative dividend leaves a negative remainder: fold it up.
  assign zero_per = (cell_i.side.period == '0);
  assign fix      = cell_i.neg && (cell_i.rem != '0) && !zero_per;
  assign r        = zero_per ? '0 : (fix ? (cell_i.side.period - cell_i.rem) : cell_i.rem);
  assign odd      = !zero_per && (cell_i.qlsb ^ fix);

  // The address wraps modulo 2^13, so only the low product bits are kept.
  assign row_diff = {{(ssp_pkg::ROW_W-ssp_pkg::PERIOD_W){1'b0}}, cell_i.side.period} - MIN_L;
  assign row_full = row_diff * ROW_L;
  assign row_off  = {{(ssp_pkg::ROW_W-3){1'b0}}, r[8:7], 1'b0};

  always_comb begin
    res.pattern_bank     = r[2:0];
    res.row_byte_address = row_full + row_off;
    res.scroll_code      = ssp_pkg::scroll_of(r[6:3]);
    res.color_out_a      = odd ? cell_i.side.color_second : cell_i.side.color_first;
    res.color_out_b      = odd ? cell_i.side.color_first  : cell_i.side.color_second;
  end

  assign en     = !skid_valid_r;
  assign arrive = valid_i && en;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    if (out_valid_r && !out_ready) begin
      // hold the output, park a new arrival in the skid entry
      if (arrive) begin
        skid_valid_nxt = 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = arrive;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (arrive && out_valid_r && !out_ready) begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign res_o     = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/scanline_stripe_scroll_params_core.sv =====
// Top level of the scanline stripe scroll parameter core.
//
// One request describes a scanline: a stripe period w in eighth pixels, a
// frame number f and two colors. The core forms (w*f)>>>3 + center_offset,
// divides it by w to get a remainder in [0, w) and the parity of the
// quotient, and returns the pattern bank (low three remainder bits), the
// byte address inside the bank ((w - MIN_PERIOD) * ROW_BYTES plus an even
// offset, modulo 2^13), the fine scroll code and the two colors, swapped
// when the quotient is odd. A zero period gives remainder zero and no swap.
// Requests enter at one per cycle while in_ready is high, and each passes
// 26 registers: one multiply stage, one offset/magnitude stage, one
// division cell per dividend bit (23 cells in a row, each doing one trial
// subtract of the period) and the output register. A two-entry output
// (register plus skid) absorbs one result when the consumer stalls; while
// the skid entry is occupied in_ready is low and the whole chain holds.
// center_offset resets to -1280 and is written through cfg_we/cfg_wdata;
// the user must write it only while no request is in flight, which the
// block does not enforce.
`default_nettype none

module scanline_stripe_scroll_params_core #(
  parameter int MIN_PERIOD = ssp_pkg::MIN_PERIOD_DEF,
  parameter int ROW_BYTES  = ssp_pkg::ROW_BYTES_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // configuration
  input  wire                          cfg_we,
  input  wire [ssp_pkg::OFFSET_W-1:0]  cfg_wdata,
  // request channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [ssp_pkg::PERIOD_W-1:0]  in_stripe_period,
  input  wire [ssp_pkg::FRAME_W-1:0]   in_frame_number,
  input  wire [ssp_pkg::COLOR_W-1:0]   in_color_first,
  input  wire [ssp_pkg::COLOR_W-1:0]   in_color_second,
  // result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [ssp_pkg::BANK_W-1:0]   out_pattern_bank,
  output logic [ssp_pkg::ROW_W-1:0]    out_row_byte_address,
  output logic [ssp_pkg::SCROLL_W-1:0] out_scroll_code,
  output logic [ssp_pkg::COLOR_W-1:0]  out_color_out_a,
  output logic [ssp_pkg::COLOR_W-1:0]  out_color_out_b
);

  localparam int NUM_CELLS = ssp_pkg::DVD_W;

  logic [ssp_pkg::OFFSET_W-1:0] center_offset_r;
  logic                         en;
  logic                         chain_valid [0:NUM_CELLS];
  ssp_pkg::ssp_cell_t           chain_cell  [0:NUM_CELLS];
  ssp_pkg::ssp_res_t            res;

  // Center offset register: written directly, no read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_offset_r <= ssp_pkg::CENTER_OFFSET_RST;
    end else if (cfg_we) begin
      center_offset_r <= cfg_wdata;
    end
  end

  // The whole chain advances together unless the skid entry is occupied.
  assign in_ready = en;

  ssp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .valid_i       (in_valid),
    .stripe_period (in_stripe_period),
    .frame_number  (in_frame_number),
    .color_first   (in_color_first),
    .color_second  (in_color_second),
    .center_offset (center_offset_r),
    .valid_o       (chain_valid[0]),
    .cell_o        (chain_cell[0])
  );

  // One cell per dividend bit, most significant bit first.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    ssp_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (chain_valid[i]),
      .cell_i  (chain_cell[i]),
      .valid_o (chain_valid[i+1]),
      .cell_o  (chain_cell[i+1])
    );
  end

  ssp_out #(
    .MIN_PERIOD (MIN_PERIOD),
    .ROW_BYTES  (ROW_BYTES)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (chain_valid[NUM_CELLS]),
    .cell_i    (chain_cell[NUM_CELLS]),
    .en        (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_o     (res)
  );

  assign out_pattern_bank     = res.pattern_bank;
  assign out_row_byte_address = res.row_byte_address;
  assign out_scroll_code      = res.scroll_code;
  assign out_color_out_a      = res.color_out_a;
  assign out_color_out_b      = res.color_out_b;

endmodule

`default_nettype wire

// ===== hw/rtl/ssp_checker.sv =====
// Port-level checker for the stripe scroll parameter core, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module ssp_port_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [ssp_pkg::BANK_W-1:0]    out_pattern_bank,
  input wire [ssp_pkg::ROW_W-1:0]     out_row_byte_address,
  input wire [ssp_pkg::SCROLL_W-1:0]  out_scroll_code,
  input wire [ssp_pkg::COLOR_W-1:0]   out_color_out_a,
  input wire [ssp_pkg::COLOR_W-1:0]   out_color_out_b
);

  localparam int PAY_W = ssp_pkg::BANK_W + ssp_pkg::ROW_W + ssp_pkg::SCROLL_W
                       + 2 * ssp_pkg::COLOR_W;

  logic [PAY_W-1:0] out_payload;

  assign out_payload = {out_pattern_bank, out_row_byte_address, out_scroll_code,
                        out_color_out_a, out_color_out_b};

  // A stalled result stays offered.
  `SSP_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")

  // A stalled result keeps its payload.
  `SSP_ASSERT_RST(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_payload), "result changed")

  // Input backpressure only follows a stalled result.
  `SSP_ASSERT_RST(a_ready_cause, clk, rst_n, !in_ready |-> $past(out_valid && !out_ready), "bad in_ready")

  // Nothing is offered right after reset.
  `SSP_ASSERT_ALWAYS(a_reset_empty, clk, $rose(rst_n) |-> !out_valid, "result out of reset")

endmodule

bind scanline_stripe_scroll_params_core ssp_port_checker u_ssp_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_pattern_bank     (out_pattern_bank),
  .out_row_byte_address (out_row_byte_address),
  .out_scroll_code      (out_scroll_code),
  .out_color_out_a      (out_color_out_a),
  .out_color_out_b      (out_color_out_b)
);

`default_nettype wire

// ===== verif/ssp_checker.sv =====
// Checker: watches the request, result and config ports, predicts each result and compares.
`timescale 1ns / 1ps

module ssp_checker
  import ssp_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire [OFFSET_W-1:0]   cfg_wdata,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  wire [PERIOD_W-1:0]   in_stripe_period,
  input  wire [FRAME_W-1:0]    in_frame_number,
  input  wire [COLOR_W-1:0]    in_color_first,
  input  wire [COLOR_W-1:0]    in_color_second,
  input  wire                  out_valid,
  input  wire                  out_ready,
  input  wire [BANK_W-1:0]     out_pattern_bank,
  input  wire [ROW_W-1:0]      out_row_byte_address,
  input  wire [SCROLL_W-1:0]   out_scroll_code,
  input  wire [COLOR_W-1:0]    out_color_out_a,
  input  wire [COLOR_W-1:0]    out_color_out_b,
  output int                   fail_count,
  output int                   pending
);

  localparam int  REPORT_LIMIT = 10;
  localparam longint SCROLL_STEP = 'h11;

  logic signed [OFFSET_W-1:0] center_offset = CENTER_OFFSET_RST;
  ssp_res_t                   scanline_queue[$];

  // Scanline parameters for one request, at full width so nothing saturates.
  function automatic ssp_res_t scanline_params(input logic [PERIOD_W-1:0] period,
                                               input logic signed [FRAME_W-1:0] frame,
                                               input logic signed [OFFSET_W-1:0] offset,
                                               input logic [COLOR_W-1:0] first,
                                               input logic [COLOR_W-1:0] second);
    longint   w;
    longint   dividend;
    longint   quo;
    longint   rem;
    longint   pix;
    longint   row;
    ssp_res_t res;
    w        = longint'(period);
    dividend = ((w * longint'(frame)) >>> 3) + longint'(offset);
    if (w == 0) begin
      quo = 0;
      rem = 0;
    end else begin
      quo = dividend / w;
      rem = dividend % w;
      if (rem < 0) begin
        rem = rem + w;
        quo = quo + 1;
      end
    end
    pix = rem >>> 3;
    row = (w - MIN_PERIOD_DEF) * ROW_BYTES_DEF + ((pix >>> 3) & ~longint'(1));
    res.pattern_bank     = BANK_W'(rem);
    res.row_byte_address = ROW_W'(row);
    res.scroll_code      = SCROLL_W'((15 - (pix & 15)) * SCROLL_STEP);
    if ((quo & 1) != 0) begin
      res.color_out_a = second;
      res.color_out_b = first;
    end else begin
      res.color_out_a = first;
      res.color_out_b = second;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    ssp_res_t got;
    ssp_res_t exp;
    if (!rst_n) begin
      center_offset = CENTER_OFFSET_RST;
      fail_count    = 0;
      scanline_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_pattern_bank, out_row_byte_address, out_scroll_code,
                out_color_out_a, out_color_out_b};
        if (scanline_queue.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("%0t: result with nothing outstanding:", $time,
                     " bank=%0d row=%0d scroll=%02h a=%03h b=%03h",
                     got.pattern_bank, got.row_byte_address, got.scroll_code,
                     got.color_out_a, got.color_out_b);
          fail_count = fail_count + 1;
        end else begin
          exp = scanline_queue.pop_front();
          if (got.pattern_bank !== exp.pattern_bank ||
              got.row_byte_address !== exp.row_byte_address ||
              got.scroll_code !== exp.scroll_code ||
              got.color_out_a !== exp.color_out_a ||
              got.color_out_b !== exp.color_out_b) begin
            if (fail_count < REPORT_LIMIT)
              $display("%0t: mismatch exp bank=%0d row=%0d scroll=%02h a=%03h b=%03h",
                       $time, exp.pattern_bank, exp.row_byte_address, exp.scroll_code,
                       exp.color_out_a, exp.color_out_b,
                       " | got bank=%0d row=%0d scroll=%02h a=%03h b=%03h",
                       got.pattern_bank, got.row_byte_address, got.scroll_code,
                       got.color_out_a, got.color_out_b);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        scanline_queue.push_back(scanline_params(in_stripe_period, in_frame_number,
                                                 center_offset, in_color_first,
                                                 in_color_second));
      if (cfg_we)
        center_offset = cfg_wdata;
    end
    pending = scanline_queue.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top: clock, reset, request and config stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps

module tb_top;
  import ssp_pkg::*;

  localparam int PHASES         = 9;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int DRAIN_CYCLES   = 40;   // comfortably past the pipeline latency

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [OFFSET_W-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [PERIOD_W-1:0] in_stripe_period;
  logic [FRAME_W-1:0]  in_frame_number;
  logic [COLOR_W-1:0]  in_color_first;
  logic [COLOR_W-1:0]  in_color_second;
  logic                out_valid;
  logic                out_ready;
  logic [BANK_W-1:0]   out_pattern_bank;
  logic [ROW_W-1:0]    out_row_byte_address;
  logic [SCROLL_W-1:0] out_scroll_code;
  logic [COLOR_W-1:0]  out_color_out_a;
  logic [COLOR_W-1:0]  out_color_out_b;
  int                  fail_count;
  int                  pending;
  logic                quiet = 1'b0;   // high: neither side idles

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  scanline_stripe_scroll_params_core u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_stripe_period     (in_stripe_period),
    .in_frame_number      (in_frame_number),
    .in_color_first       (in_color_first),
    .in_color_second      (in_color_second),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_pattern_bank     (out_pattern_bank),
    .out_row_byte_address (out_row_byte_address),
    .out_scroll_code      (out_scroll_code),
    .out_color_out_a      (out_color_out_a),
    .out_color_out_b      (out_color_out_b)
  );

  ssp_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_stripe_period     (in_stripe_period),
    .in_frame_number      (in_frame_number),
    .in_color_first       (in_color_first),
    .in_color_second      (in_color_second),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_pattern_bank     (out_pattern_bank),
    .out_row_byte_address (out_row_byte_address),
    .out_scroll_code      (out_scroll_code),
    .out_color_out_a      (out_color_out_a),
    .out_color_out_b      (out_color_out_b),
    .fail_count           (fail_count),
    .pending              (pending)
  );

  // Idle length: mostly none or short, now and then a long one.
  function automatic int idle_cycles();
    int pick;
    if (quiet)
      return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      return 0;
    if (pick < 90)
      return $urandom_range(1, 3);
    if (pick < 98)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request; entered and left at a falling edge.
  task automatic push_request(input logic [PERIOD_W-1:0] period,
                              input logic [FRAME_W-1:0] frame,
                              input logic [COLOR_W-1:0] first,
                              input logic [COLOR_W-1:0] second);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      // drop valid for the gap, then come back with the new request
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_stripe_period = period;
    in_frame_number  = frame;
    in_color_first   = first;
    in_color_second  = second;
    in_valid         = 1'b1;
    // hold the request until the core takes it
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Random scanline: mostly in-range periods, some anywhere in the field.
  task automatic push_random_request();
    int                  pick;
    logic [PERIOD_W-1:0] period;
    logic [FRAME_W-1:0]  frame;
    pick = $urandom_range(0, 99);
    if (pick < 78)
      period = PERIOD_W'($urandom_range(MIN_PERIOD_DEF, 296));
    else if (pick < 86)
      period = PERIOD_W'($urandom_range(0, 16));
    else
      period = PERIOD_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 88)
      frame = FRAME_W'($urandom);
    else if (pick < 91)
      frame = 16'h8000;
    else if (pick < 94)
      frame = 16'h7FFF;
    else if (pick < 97)
      frame = 16'h0000;
    else
      frame = 16'hFFFF;
    push_request(period, frame, COLOR_W'($urandom), COLOR_W'($urandom));
  endtask

  // Wait until every request has its result, so the register may change.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_center_offset(input logic [OFFSET_W-1:0] value);
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Result side: stall at random, released again after each stall.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = idle_cycles();
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  initial begin
    logic [OFFSET_W-1:0] offset;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_stripe_period = '0;
    in_frame_number  = '0;
    in_color_first   = '0;
    in_color_second  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed requests at the reset offset: field extremes and corner periods.
    push_request(9'd168, 16'h0000, 12'h000, 12'hFFF);
    push_request(9'd296, 16'h7FFF, 12'hFFF, 12'h000);
    push_request(9'd296, 16'h8000, 12'hAAA, 12'h555);
    push_request(9'd168, 16'h8000, 12'h555, 12'hAAA);
    push_request(9'd168, 16'h7FFF, 12'h123, 12'h456);
    push_request(9'd200, 16'hFFFF, 12'hF00, 12'h0F0);
    push_request(9'd200, 16'h0001, 12'h00F, 12'hFF0);
    // zero period: no divide, no swap
    push_request(9'd0, 16'h04D2, 12'hABC, 12'hDEF);
    push_request(9'd0, 16'h8000, 12'h111, 12'h222);
    // small periods: quotient far larger than the period
    push_request(9'd1, 16'h7FFF, 12'h333, 12'h444);
    push_request(9'd1, 16'h8000, 12'h444, 12'h333);
    push_request(9'd1, 16'hFFFF, 12'h777, 12'h888);
    push_request(9'd3, 16'h1234, 12'h999, 12'h666);
    push_request(9'd7, 16'hCDEF, 12'hFFF, 12'hFFF);
    // periods outside the table range, some with a wrapping address, then 256 and 255
    push_request(9'd167, 16'h0100, 12'h0AA, 12'h055);
    push_request(9'd297, 16'h0200, 12'h055, 12'h0AA);
    push_request(9'd511, 16'h7FFF, 12'hFFF, 12'h000);
    push_request(9'd511, 16'h8000, 12'h000, 12'hFFF);
    push_request(9'd256, 16'h5A5A, 12'hA5A, 12'h5A5);
    push_request(9'd255, 16'hA5A5, 12'h5A5, 12'hA5A);

    // Random phases, each under its own center offset, extremes first.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0:       offset = 17'h00000;
        1:       offset = 17'h0FFFF;
        2:       offset = 17'h10000;
        3:       offset = 17'h00001;
        4:       offset = 17'h1FFFF;
        5:       offset = CENTER_OFFSET_RST;
        default: offset = OFFSET_W'($urandom);
      endcase
      write_center_offset(offset);
      // run a couple of phases flat out on both sides
      quiet = (phase == 2) || (phase == 6);
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        push_random_request();
    end
    quiet = 1'b0;

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_front.sv
hw/rtl/ssp_div_cell.sv
hw/rtl/ssp_out.sv
hw/rtl/scanline_stripe_scroll_params_core.sv
hw/rtl/ssp_checker.sv
verif/ssp_checker.sv
verif/tb_top.sv
